[rtl/zbp_pkg.sv]
`default_nettype none
package zbp_pkg;

   // fixed field widths
   localparam int BYTE_W    = 8;
   localparam int MAX_GROUP = 8;
   localparam int POS_W     = 3;
   localparam int CNT_W     = 4;

   // group queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // one finished group: compacted nonzero bytes, presence mask, byte count, message-end flag
   typedef struct packed {
      logic [MAX_GROUP-1:0][BYTE_W-1:0] data;
      logic [BYTE_W-1:0]                mask;
      logic [CNT_W-1:0]                 count;
      logic                             last;
   } group_rec_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage
`default_nettype wire

[rtl/zbp_req_if.sv]
`default_nettype none
interface zbp_req_if;
   import zbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

[rtl/zbp_rsp_if.sv]
`default_nettype none
interface zbp_rsp_if;
   import zbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_is_mask;
   logic              out_last;

   modport source (output valid, output out_byte, output out_is_mask, output out_last,
                   input ready);
   modport sink (input valid, input out_byte, input out_is_mask, input out_last,
                 output ready);
endinterface
`default_nettype wire

[rtl/zbp_front.sv]
`default_nettype none
module zbp_front #(
   parameter int GROUP_SIZE = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   zbp_req_if.sink                     req_if,
   input  wire zbp_pkg::queue_stat_type q_stat,
   output logic                        push,
   output zbp_pkg::group_rec_type      push_rec
);
   import zbp_pkg::*;

   logic [CNT_W-1:0]                 fill_ff, fill_in;
   logic [CNT_W-1:0]                 nz_cnt_ff, nz_cnt_in;
   logic [BYTE_W-1:0]                mask_ff, mask_in;
   logic [MAX_GROUP-1:0][BYTE_W-1:0] buf_ff, buf_in;

   logic              accept;
   logic              nonzero;
   logic              group_end;
   logic [POS_W-1:0]  pos;
   logic [BYTE_W-1:0] mask_set;

   // hold off requests while the queue has no room for a closing group
   assign req_if.ready = !q_stat.full;
   assign accept       = req_if.valid && req_if.ready;

   // classify the request and merge it into the open group
   always_comb begin
      pos       = fill_ff[POS_W-1:0];
      nonzero   = (req_if.in_byte != '0);
      group_end = req_if.in_last || (fill_ff == CNT_W'(GROUP_SIZE - 1));
      mask_set  = mask_ff;
      mask_set[pos] = nonzero;
      buf_in    = buf_ff;
      if (nonzero) begin
         buf_in[nz_cnt_ff[POS_W-1:0]] = req_if.in_byte;
      end
   end

   // close the group into a queue record
   always_comb begin
      push           = accept && group_end;
      push_rec.data  = buf_in;
      push_rec.mask  = mask_set;
      push_rec.count = nz_cnt_ff + CNT_W'(nonzero);
      push_rec.last  = req_if.in_last;
   end

   // advance fill count and mask, clear them when a group closes
   always_comb begin
      fill_in   = fill_ff;
      nz_cnt_in = nz_cnt_ff;
      mask_in   = mask_ff;
      if (accept) begin
         if (group_end) begin
            fill_in   = '0;
            nz_cnt_in = '0;
            mask_in   = '0;
         end else begin
            fill_in   = fill_ff + CNT_W'(1);
            nz_cnt_in = nz_cnt_ff + CNT_W'(nonzero);
            mask_in   = mask_set;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         nz_cnt_ff <= '0;
         mask_ff   <= '0;
      end else begin
         fill_ff   <= fill_in;
         nz_cnt_ff <= nz_cnt_in;
         mask_ff   <= mask_in;
      end
   end

   // compacted bytes need no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= buf_in;
      end
   end

endmodule
`default_nettype wire

[rtl/zbp_queue.sv]
`default_nettype none
module zbp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire zbp_pkg::group_rec_type push_rec,
   input  wire logic                   pop,
   output zbp_pkg::group_rec_type      head_rec,
   output zbp_pkg::queue_stat_type     q_stat
);
   import zbp_pkg::*;

   group_rec_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_rec     = entries_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule
`default_nettype wire

[rtl/zbp_back.sv]
`default_nettype none
module zbp_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire zbp_pkg::group_rec_type  head_rec,
   input  wire zbp_pkg::queue_stat_type q_stat,
   output logic                         pop,
   zbp_rsp_if.source                    rsp_if
);
   import zbp_pkg::*;

   group_rec_type     cur_ff;
   logic              cur_valid_ff, cur_valid_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_is_mask_ff, out_is_mask_in;
   logic              out_last_ff, out_last_in;

   logic             out_free;
   logic             emit;
   logic             final_item;
   logic [POS_W-1:0] sel;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign pop      = !cur_valid_ff && !q_stat.empty;
   assign emit     = cur_valid_ff && out_free;

   // walk mask first, then the compacted bytes
   always_comb begin
      final_item     = (idx_ff == cur_ff.count);
      sel            = POS_W'(idx_ff - CNT_W'(1));
      cur_valid_in   = cur_valid_ff;
      idx_in         = idx_ff;
      out_valid_in   = out_valid_ff;
      out_byte_in    = out_byte_ff;
      out_is_mask_in = out_is_mask_ff;
      out_last_in    = out_last_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
      if (emit) begin
         out_valid_in   = 1'b1;
         out_is_mask_in = (idx_ff == '0);
         out_byte_in    = (idx_ff == '0) ? cur_ff.mask : cur_ff.data[sel];
         out_last_in    = final_item && cur_ff.last;
         if (final_item) begin
            cur_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_rec;
      end
      out_byte_ff    <= out_byte_in;
      out_is_mask_ff <= out_is_mask_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.out_byte    = out_byte_ff;
   assign rsp_if.out_is_mask = out_is_mask_ff;
   assign rsp_if.out_last    = out_last_ff;

endmodule
`default_nettype wire

[rtl/zero_byte_packer.sv]
// Zero-byte packer.
// req_if carries raw bytes (in_byte) with a message-end flag (in_last).
// Bytes are grouped GROUP_SIZE at a time; a group closes on its last slot
// or on a request with in_last set, so the final group may be short.
// rsp_if returns each group as a presence-mask byte (out_is_mask = 1, bit i
// set when byte i was nonzero) followed by the nonzero bytes in order;
// out_last marks the final packed byte of a message.
// Requests are taken one per cycle while the two-entry group queue has room.
// A group with k nonzero bytes is first loaded from the queue, then sent as k + 1
// responses (the mask, then each nonzero byte), one per cycle while rsp_if.ready holds.
// From the closing request to its mask byte on rsp_if, a group passes through the
// queue entry, the current-group register and the output register.
// Reset (synchronous) empties the open group, the queue and the output
// register; no response is valid after reset.
// When rsp_if.ready is low the output register holds, the back end stops,
// and closed groups collect in the queue; req_if.ready drops once the
// queue holds two groups.
`default_nettype none
module zero_byte_packer #(
   parameter int GROUP_SIZE = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   zbp_req_if.sink   req_if,
   zbp_rsp_if.source rsp_if
);
   import zbp_pkg::*;

   logic           push;
   logic           pop;
   group_rec_type  push_rec;
   group_rec_type  head_rec;
   queue_stat_type q_stat;

   zbp_front #(
      .GROUP_SIZE (GROUP_SIZE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_stat   (q_stat),
      .push     (push),
      .push_rec (push_rec)
   );

   zbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_stat   (q_stat)
   );

   zbp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_rec (head_rec),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

   // never write a full queue or read an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("group pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("group popped from empty queue");

   // data bytes on the output are never zero
   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.out_is_mask) |-> (rsp_if.out_byte != '0))
      else $error("zero data byte emitted");

   // a mask byte with bits set cannot be the last byte of a message
   a_mask_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.out_is_mask && (rsp_if.out_byte != '0))
         |-> !rsp_if.out_last)
      else $error("nonempty mask flagged as last");

   // nothing valid right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid after reset");

endmodule
`default_nettype wire
